@@ hw/rtl/ssd_pkg.sv @@
// Package: widths, payload and frame summary types, and the back-end state type.
`default_nettype none

package ssd_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int SAMPLE_W    = 16;
    localparam int STD_W       = 16;
    localparam int STD_CEIL    = 32768;
    localparam int QUEUE_DEPTH = 2;

    localparam int LEN_LOG  = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int SUM_W    = LEN_LOG + SAMPLE_W;
    localparam int SQ_W     = LEN_LOG + 2 * SAMPLE_W - 1;
    localparam int NUM_W    = CNT_W + SQ_W;
    localparam int DEN_W    = 2 * CNT_W;
    localparam int ROOT_W   = (NUM_W + 1) / 2;
    localparam int SQV_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 2;
    localparam int STEP_W   = $clog2(NUM_W);
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } ssd_in_t;

    typedef struct packed {
        logic [STD_W-1:0] std_dev;
        logic             too_few;
        logic             too_long;
    } ssd_out_t;

    // Totals of one finished frame, classified by the front end.
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
        logic                    too_few;
        logic                    too_long;
    } ssd_frame_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUB,
        BK_DIV,
        BK_SQRT,
        BK_OUT
    } ssd_back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssd_front.sv @@
// Front end: accumulates count, sum and sum of squares, and classifies each frame.
`default_nettype none

module ssd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire ssd_pkg::ssd_in_t   request,
    output logic                    push,
    output ssd_pkg::ssd_frame_t     frame
);
    import ssd_pkg::*;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sumsq_reg, sumsq_next;
    logic                    ovf_reg, ovf_next;
    logic signed [2*SAMPLE_W-1:0] square;

    assign square = request.sample * request.sample;

    always_comb
    begin
        ovf_next   = ovf_reg || (count_reg >= CNT_W'(MAX_LEN));
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        if (!ovf_next)
        begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(request.sample);
            sumsq_next = sumsq_reg + SQ_W'(unsigned'(square));
        end
    end

    assign push           = accept && request.last;
    assign frame.count    = count_next;
    assign frame.sum      = sum_next;
    assign frame.sumsq    = sumsq_next;
    assign frame.too_long = ovf_next;
    assign frame.too_few  = !ovf_next && (count_next < CNT_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (request.last)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sumsq_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                sumsq_reg <= sumsq_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ssd_queue.sv @@
// Short queue of finished frame summaries between the front and back ends.
`default_nettype none

module ssd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ssd_pkg::ssd_frame_t push_frame,
    input  wire logic                pop,
    output ssd_pkg::ssd_frame_t      head,
    output logic                     full,
    output logic                     avail
);
    import ssd_pkg::*;

    ssd_frame_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign head    = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ssd_back.sv @@
// Back end: variance by multiply, subtract and restoring divide, then a digit-by-digit root.
`default_nettype none

module ssd_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                avail,
    input  wire ssd_pkg::ssd_frame_t head,
    output logic                     pop,
    output logic                     done,
    output ssd_pkg::ssd_out_t        result
);
    import ssd_pkg::*;

    ssd_back_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg;

    ssd_frame_t        frame_reg;
    logic [NUM_W-1:0]  nsq_reg, s2_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  div_q_reg;
    logic [DEN_W-1:0]  div_rem_reg;
    logic [SQV_W-1:0]  sq_val_reg;
    logic [REM_W-1:0]  sq_rem_reg;
    logic [ROOT_W-1:0] root_reg;
    ssd_out_t          res_reg;

    logic [SUM_W-1:0]  mag;
    logic [DEN_W:0]    div_sh;
    logic              div_ge;
    logic [REM_W-1:0]  sq_t, sq_trial;
    logic              sq_ge;
    logic              div_last, sq_last;
    logic [ROOT_W-1:0] root_fin;

    assign mag = frame_reg.sum[SUM_W-1] ? unsigned'(-frame_reg.sum) : unsigned'(frame_reg.sum);

    assign div_sh = {div_rem_reg, div_q_reg[NUM_W-1]};
    assign div_ge = div_sh >= {1'b0, den_reg};

    assign sq_t     = {sq_rem_reg[ROOT_W-1:0], sq_val_reg[SQV_W-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;
    assign root_fin = {root_reg[ROOT_W-2:0], sq_ge};

    assign div_last = (step_reg == STEP_W'(NUM_W - 1));
    assign sq_last  = (step_reg == STEP_W'(ROOT_W - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (avail)
                    state_next = (head.too_few || head.too_long) ? BK_OUT : BK_MUL;
            end
            BK_MUL:  state_next = BK_SUB;
            BK_SUB:  state_next = BK_DIV;
            BK_DIV:  state_next = div_last ? BK_SQRT : BK_DIV;
            BK_SQRT: state_next = sq_last ? BK_OUT : BK_SQRT;
            BK_OUT:  state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        done = 1'b0;
        case (state_reg)
            BK_IDLE: pop  = avail;
            BK_OUT:  done = 1'b1;
            default:
            begin
                pop  = 1'b0;
                done = 1'b0;
            end
        endcase
    end

    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == BK_DIV && !div_last) || (state_reg == BK_SQRT && !sq_last))
                step_reg <= step_reg + STEP_W'(1);
            else
                step_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                frame_reg        <= head;
                res_reg.std_dev  <= '0;
                res_reg.too_few  <= head.too_few;
                res_reg.too_long <= head.too_long;
            end
            BK_MUL:
            begin
                nsq_reg <= NUM_W'(frame_reg.count) * NUM_W'(frame_reg.sumsq);
                s2_reg  <= NUM_W'(mag) * NUM_W'(mag);
                den_reg <= DEN_W'(frame_reg.count) * DEN_W'(frame_reg.count - CNT_W'(1));
            end
            BK_SUB:
            begin
                div_q_reg   <= nsq_reg - s2_reg;
                div_rem_reg <= '0;
            end
            BK_DIV:
            begin
                div_rem_reg <= div_ge ? DEN_W'(div_sh - {1'b0, den_reg}) : DEN_W'(div_sh);
                div_q_reg   <= {div_q_reg[NUM_W-2:0], div_ge};
                if (div_last)
                begin
                    sq_val_reg <= SQV_W'({div_q_reg[NUM_W-2:0], div_ge});
                    sq_rem_reg <= '0;
                    root_reg   <= '0;
                end
            end
            BK_SQRT:
            begin
                sq_rem_reg <= sq_ge ? sq_t - sq_trial : sq_t;
                sq_val_reg <= {sq_val_reg[SQV_W-3:0], 2'b00};
                root_reg   <= root_fin;
                if (sq_last)
                begin
                    // Roots above the Q1.15 full scale clip to it.
                    if (root_fin > ROOT_W'(STD_CEIL))
                        res_reg.std_dev <= STD_W'(STD_CEIL);
                    else
                        res_reg.std_dev <= STD_W'(root_fin);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/sample_standard_deviation_core.sv @@
// Top level of the sample standard deviation core.
`default_nettype none

// Samples of a frame are taken one per clock cycle while busy is low; a request is
// accepted at an edge where start is high and busy is low, and request.last closes the
// frame. The front end folds each sample into the count, sum and sum of squares in that
// cycle and hands the finished frame to a two-entry queue. The back end works through one
// queued frame at a time: setup steps that take the frame, multiply and subtract, a
// restoring divider that yields one quotient bit per cycle, a square root that yields one
// root bit per cycle, and the result state. Frames flagged too short or too long skip the
// arithmetic and go straight from taking the frame to the result state. The result appears
// on result for exactly one cycle with done high and is not held, so the receiver must
// take it in that cycle. busy is high only while both queue entries hold frames, which
// happens when closing frames arrive faster than one per back-end pass.
module sample_standard_deviation_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ssd_pkg::ssd_in_t  request,
    output logic                   done,
    output ssd_pkg::ssd_out_t      result
);
    import ssd_pkg::*;

    logic       accept, push, pop, full, avail;
    ssd_frame_t push_frame, head;

    assign busy   = full;
    assign accept = start && !full;

    ssd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .push    (push),
        .frame   (push_frame)
    );

    ssd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .avail      (avail)
    );

    ssd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (avail),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

@@ hw/rtl/ssd_checker.sv @@
// Port-level checker for the sample standard deviation core, with its bind.
`default_nettype none

module ssd_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire ssd_pkg::ssd_in_t  request,
    input wire logic              done,
    input wire ssd_pkg::ssd_out_t result
);
    import ssd_pkg::*;

    // The back end passes through idle between two results, so done is never high twice in a row.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("two results in consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.too_few && result.too_long))
        else $error("short and long flags both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.too_few || result.too_long)) |-> (result.std_dev == '0))
        else $error("flagged frame with nonzero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.std_dev <= STD_W'(STD_CEIL)))
        else $error("result above full scale");

    // An accepted request must carry a fully defined sample and marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !$isunknown(request))
        else $error("accepted request with unknown bits");

endmodule

bind sample_standard_deviation_core ssd_checker u_ssd_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

`default_nettype wire
